// File: design/hcs_pkg.sv
`timescale 1ns / 1ps

package hcs_pkg;

  localparam int SAT_W = 17;
  localparam int LIT_W = 18;
  localparam int HUE_W = 19;
  localparam int QUO_W = 19;
  localparam int FIELD_W = 16;
  localparam int RATIO_FRAC = 14;

  localparam logic [HUE_W-1:0] SEXT = HUE_W'(32'd65536);
  localparam logic [SAT_W-1:0] SAT_ONE = SAT_W'(32'd65536);
  localparam logic [LIT_W-1:0] LIT_ONE = LIT_W'(32'd131072);
  localparam logic [LIT_W-1:0] LIT_HALF = LIT_W'(32'd65536);

  typedef enum logic {
    OP_SHADE = 1'b0,
    OP_SATURATE = 1'b1
  } op_t;

  typedef struct packed {
    logic grey;
    op_t op;
    logic [LIT_W-1:0] lit;
    logic [FIELD_W-1:0] ratio;
    logic [FIELD_W-1:0] alpha;
  } side_t;

endpackage

// File: design/hcs_if.sv
`timescale 1ns / 1ps

interface hcs_in_if;
  logic valid;
  logic ready;
  logic opcode;
  logic [15:0] red_in;
  logic [15:0] green_in;
  logic [15:0] blue_in;
  logic [15:0] alpha_in;
  logic [15:0] ratio;
  modport source (output valid, opcode, red_in, green_in, blue_in, alpha_in, ratio,
                  input ready);
  modport sink (input valid, opcode, red_in, green_in, blue_in, alpha_in, ratio,
                output ready);
endinterface

interface hcs_out_if;
  logic valid;
  logic ready;
  logic [15:0] red_out;
  logic [15:0] green_out;
  logic [15:0] blue_out;
  logic [15:0] alpha_out;
  modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
  modport sink (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

// File: design/hcs_front.sv
`timescale 1ns / 1ps

module hcs_front #(
  parameter int CB = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic opcode,
  input  logic [15:0] red_in,
  input  logic [15:0] green_in,
  input  logic [15:0] blue_in,
  input  logic [15:0] alpha_in,
  input  logic [15:0] ratio,
  output logic valid,
  output logic [CB+2:0] num,
  output logic [CB:0] den,
  output logic [CB-1:0] delta,
  output hcs_pkg::side_t side
);

  localparam logic [CB+1:0] ONE = (CB+2)'(1) << CB;

  logic [CB-1:0] r, g, b, mx, mn, dl;
  logic [CB+1:0] sum;
  logic [CB+2:0] d2, d4, d6, n;
  logic [CB:0] dn;
  hcs_pkg::side_t sd;

  always_comb begin
    r = red_in[CB-1:0];
    g = green_in[CB-1:0];
    b = blue_in[CB-1:0];
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    sum = (CB+2)'(mx) + (CB+2)'(mn);
    dl = mx - mn;
    dn = (sum <= ONE) ? sum[CB:0] : (CB+1)'((ONE << 1) - sum);
    d2 = (CB+3)'(dl) << 1;
    d4 = (CB+3)'(dl) << 2;
    d6 = d2 + d4;
    if (r == mx) begin
      n = (g >= b) ? (CB+3)'(g - b) : d6 - (CB+3)'(b - g);
    end else if (g == mx) begin
      n = (b >= r) ? d2 + (CB+3)'(b - r) : d2 - (CB+3)'(r - b);
    end else begin
      n = (r >= g) ? d4 + (CB+3)'(r - g) : d4 - (CB+3)'(g - r);
    end
    sd.grey = (dl == '0);
    sd.op = hcs_pkg::op_t'(opcode);
    sd.lit = hcs_pkg::LIT_W'(sum) << (16 - CB);
    sd.ratio = ratio;
    sd.alpha = 16'(alpha_in[CB-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num <= n;
      den <= dn;
      delta <= dl;
      side <= sd;
    end
  end

endmodule

// File: design/hcs_divider.sv
`timescale 1ns / 1ps

module hcs_divider #(
  parameter int NW = 35,
  parameter int DW = 17,
  parameter int QW = 19,
  parameter int PW = 1
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  input  logic [PW-1:0] payload_in,
  output logic out_valid,
  output logic [QW-1:0] quotient,
  output logic [PW-1:0] payload_out
);

  logic v [QW];
  logic [DW-1:0] rem [QW];
  logic [QW-1:0] low [QW];
  logic [QW-1:0] q [QW];
  logic [DW-1:0] dv [QW];
  logic [PW-1:0] pl [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic v_p;
    logic [DW-1:0] rem_p, dv_p;
    logic [QW-1:0] low_p, q_p;
    logic [PW-1:0] pl_p;
    logic [DW:0] trial;
    logic fits;

    if (i == 0) begin : g_first
      assign v_p = in_valid;
      assign rem_p = DW'(dividend >> QW);
      assign low_p = dividend[QW-1:0];
      assign q_p = '0;
      assign dv_p = divisor;
      assign pl_p = payload_in;
    end else begin : g_next
      assign v_p = v[i-1];
      assign rem_p = rem[i-1];
      assign low_p = low[i-1];
      assign q_p = q[i-1];
      assign dv_p = dv[i-1];
      assign pl_p = pl[i-1];
    end

    assign trial = {rem_p, low_p[QW-1]};
    assign fits = trial >= {1'b0, dv_p};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en) begin
        v[i] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= fits ? DW'(trial - {1'b0, dv_p}) : DW'(trial);
        low[i] <= low_p << 1;
        q[i] <= {q_p[QW-2:0], fits};
        dv[i] <= dv_p;
        pl[i] <= pl_p;
      end
    end
  end

  assign out_valid = v[QW-1];
  assign quotient = q[QW-1];
  assign payload_out = pl[QW-1];

endmodule

// File: design/hcs_back.sv
`timescale 1ns / 1ps

module hcs_back #(
  parameter int CB = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [hcs_pkg::QUO_W-1:0] sat,
  input  logic [hcs_pkg::QUO_W-1:0] hue,
  input  hcs_pkg::side_t side,
  output logic valid,
  output logic [15:0] red_out,
  output logic [15:0] green_out,
  output logic [15:0] blue_out,
  output logic [15:0] alpha_out
);

  localparam int LW = hcs_pkg::LIT_W;
  localparam int SW = hcs_pkg::SAT_W;
  localparam int HW = hcs_pkg::HUE_W;
  localparam logic [CB:0] TOP = {1'b0, {CB{1'b1}}};

  logic v1, v2, v3, v4;
  logic [SW-1:0] sat1;
  logic [LW-1:0] lit1, lit2, m2, m1, diff;
  logic [HW-1:0] hue1;
  logic [HW:0] tr, tg, tb;
  logic [15:0] a1, a2, a3, a4;
  logic [SW-1:0] fr, fg, fb;
  logic [LW-1:0] cr, cg, cb;

  logic [SW+15:0] sat_prod;
  logic [LW+15:0] lit_prod;
  logic [SW-1:0] sat_s;
  logic [LW-1:0] lit_s;
  logic [2*LW-1:0] m2_prod;
  logic [LW-1:0] m2_n;
  logic [HW:0] tr_n, tb_n;
  logic [LW:0] m1_n;

  function automatic logic [hcs_pkg::SAT_W-1:0] ramp(input logic [hcs_pkg::HUE_W:0] t);
    logic [hcs_pkg::HUE_W:0] s;
    s = (hcs_pkg::HUE_W+1)'(hcs_pkg::SEXT);
    if (t < s) return hcs_pkg::SAT_W'(t);
    if (t < 3 * s) return hcs_pkg::SAT_W'(s);
    if (t < 4 * s) return hcs_pkg::SAT_W'(4 * s - t);
    return '0;
  endfunction

  function automatic logic [15:0] to_chan(input logic [hcs_pkg::LIT_W-1:0] c);
    logic [CB:0] s;
    s = (CB+1)'(c >> (17 - CB));
    return 16'((s > TOP) ? TOP : s);
  endfunction

  always_comb begin
    sat_prod = (SW+16)'(sat[SW-1:0]) * (SW+16)'(side.ratio);
    lit_prod = (LW+16)'(side.lit) * (LW+16)'(side.ratio);
    if (side.grey) begin
      sat_s = '0;
    end else if ((sat_prod >> hcs_pkg::RATIO_FRAC) > (SW+16)'(hcs_pkg::SAT_ONE)) begin
      sat_s = hcs_pkg::SAT_ONE;
    end else begin
      sat_s = SW'(sat_prod >> hcs_pkg::RATIO_FRAC);
    end
    if (side.op == hcs_pkg::OP_SATURATE) begin
      lit_s = side.lit;
    end else if ((lit_prod >> hcs_pkg::RATIO_FRAC) > (LW+16)'(hcs_pkg::LIT_ONE)) begin
      lit_s = hcs_pkg::LIT_ONE;
    end else begin
      lit_s = LW'(lit_prod >> hcs_pkg::RATIO_FRAC);
    end
  end

  always_comb begin
    if (lit1 <= hcs_pkg::LIT_HALF) begin
      m2_prod = (2*LW)'(lit1) * (2*LW)'(LW'(hcs_pkg::SAT_ONE) + LW'(sat1));
    end else begin
      m2_prod = (2*LW)'(lit1) * (2*LW)'(LW'(hcs_pkg::SAT_ONE) - LW'(sat1))
              + ((2*LW)'(sat1) << 17);
    end
    m2_n = LW'(m2_prod >> 16);
    tr_n = (HW+1)'(hue1) + ((HW+1)'(hcs_pkg::SEXT) << 1);
    if (tr_n >= 6 * (HW+1)'(hcs_pkg::SEXT)) tr_n = tr_n - 6 * (HW+1)'(hcs_pkg::SEXT);
    tb_n = (HW+1)'(hue1) + ((HW+1)'(hcs_pkg::SEXT) << 2);
    if (tb_n >= 6 * (HW+1)'(hcs_pkg::SEXT)) tb_n = tb_n - 6 * (HW+1)'(hcs_pkg::SEXT);
    m1_n = ((LW+1)'(lit2) << 1) - (LW+1)'(m2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat1 <= sat_s;
      lit1 <= lit_s;
      hue1 <= hue;
      a1 <= side.alpha;
      m2 <= m2_n;
      lit2 <= lit1;
      tr <= tr_n;
      tg <= (HW+1)'(hue1);
      tb <= tb_n;
      a2 <= a1;
      m1 <= LW'(m1_n);
      diff <= m2 - LW'(m1_n);
      fr <= ramp(tr);
      fg <= ramp(tg);
      fb <= ramp(tb);
      a3 <= a2;
      cr <= m1 + LW'(((LW+SW)'(diff) * (LW+SW)'(fr)) >> 16);
      cg <= m1 + LW'(((LW+SW)'(diff) * (LW+SW)'(fg)) >> 16);
      cb <= m1 + LW'(((LW+SW)'(diff) * (LW+SW)'(fb)) >> 16);
      a4 <= a3;
      red_out <= to_chan(cr);
      green_out <= to_chan(cg);
      blue_out <= to_chan(cb);
      alpha_out <= a4;
    end
  end

endmodule

// File: design/hsl_color_shade_unit.sv
`timescale 1ns / 1ps

// channel   role    fields
// pix_in    sink    opcode, red_in, green_in, blue_in, alpha_in, ratio
// pix_out   source  red_out, green_out, blue_out, alpha_out
//
// One pixel per cycle unless the output stalls; one front stage, 19 divider
// stages (one quotient bit each, hue and saturation side by side), and five
// back stages. Synchronous reset clears only the valid bits.
// The whole pipeline holds while the output register is full and not taken.

module hsl_color_shade_unit #(
  parameter int CHANNEL_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  hcs_in_if.sink pix_in,
  hcs_out_if.source pix_out
);

  localparam int CB = CHANNEL_BITS;
  localparam int NW = CB + 19;
  localparam int QW = hcs_pkg::QUO_W;
  localparam int PW = $bits(hcs_pkg::side_t);

  logic en;
  logic f_valid, s_valid, h_valid;
  logic [CB+2:0] f_num;
  logic [CB:0] f_den;
  logic [CB-1:0] f_delta;
  hcs_pkg::side_t f_side, h_side;
  logic s_grey;
  logic [QW-1:0] s_q, h_q;

  assign en = !pix_out.valid || pix_out.ready;
  assign pix_in.ready = en;

  hcs_front #(.CB(CB)) u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(pix_in.valid),
    .opcode(pix_in.opcode), .red_in(pix_in.red_in), .green_in(pix_in.green_in),
    .blue_in(pix_in.blue_in), .alpha_in(pix_in.alpha_in), .ratio(pix_in.ratio),
    .valid(f_valid), .num(f_num), .den(f_den), .delta(f_delta), .side(f_side)
  );

  hcs_divider #(.NW(NW), .DW(CB+1), .QW(QW), .PW(1)) u_sat_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(f_valid),
    .dividend(NW'(f_delta) << 16), .divisor(f_den), .payload_in(f_side.grey),
    .out_valid(s_valid), .quotient(s_q), .payload_out(s_grey)
  );

  hcs_divider #(.NW(NW), .DW(CB+1), .QW(QW), .PW(PW)) u_hue_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(f_valid),
    .dividend(NW'(f_num) << 16), .divisor((CB+1)'(f_delta)), .payload_in(f_side),
    .out_valid(h_valid), .quotient(h_q), .payload_out(h_side)
  );

  hcs_back #(.CB(CB)) u_back (
    .clk(clk), .rst(rst), .en(en), .in_valid(h_valid),
    .sat(s_q), .hue(h_q), .side(h_side),
    .valid(pix_out.valid), .red_out(pix_out.red_out), .green_out(pix_out.green_out),
    .blue_out(pix_out.blue_out), .alpha_out(pix_out.alpha_out)
  );

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid && !pix_out.ready |-> !pix_in.ready)
    else $error("input taken during output stall");

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    s_valid == h_valid && (!h_valid || s_grey == h_side.grey))
    else $error("dividers out of step");

  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    s_valid && !s_grey |-> s_q <= QW'(hcs_pkg::SAT_ONE))
    else $error("saturation quotient out of range");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    h_valid && !h_side.grey |-> s_q <= QW'(hcs_pkg::SAT_ONE) && h_q < 6 * QW'(hcs_pkg::SEXT))
    else $error("hue quotient out of range");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    hcs_pkg::op_t op;
    logic [15:0] r, g, b, a, ratio;
  } pixel_t;

  typedef struct {
    logic [15:0] r, g, b, a;
  } rgba_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hcs_in_if pix_in ();
  hcs_out_if pix_out ();

  hsl_color_shade_unit #(.CHANNEL_BITS(16)) u_top (
    .clk(clk),
    .rst(rst),
    .pix_in(pix_in.sink),
    .pix_out(pix_out.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pixel_t pending_pixels[$];
  rgba_t shaded_pixels[$];
  int errors = 0;
  int cycles = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit hold_for_drain = 1'b0;
  bit stim_done = 1'b0;

  function automatic longint unsigned ramp(longint unsigned t, longint unsigned m1,
                                           longint unsigned m2);
    longint unsigned sx;
    sx = 64'd65536;
    if (t < sx) return m1 + (((m2 - m1) * t) >> 16);
    if (t < 3 * sx) return m2;
    if (t < 4 * sx) return m1 + (((m2 - m1) * (4 * sx - t)) >> 16);
    return m1;
  endfunction

  function automatic logic [15:0] chan(longint unsigned v);
    longint unsigned c;
    c = v >> 1;
    return (c > 65535) ? 16'hffff : c[15:0];
  endfunction

  function automatic rgba_t shade_pixel(pixel_t p);
    longint unsigned r, g, b, mx, mn, sum, delta, sat, lit, hue, m1, m2, den, num, full;
    longint unsigned ro, go, bo;
    rgba_t res;
    r = p.r; g = p.g; b = p.b;
    full = 6 * 64'd65536;
    mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
    mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
    sum = mx + mn;
    delta = mx - mn;
    lit = sum;
    sat = 0;
    hue = 0;
    if (delta != 0) begin
      den = (sum <= 65536) ? sum : (131072 - sum);
      sat = (delta << 16) / den;
      if (r == mx) num = (g >= b) ? (g - b) : (6 * delta - (b - g));
      else if (g == mx) num = 2 * delta + b - r;
      else num = 4 * delta + r - g;
      hue = (num << 16) / delta;
    end
    sat = (sat * p.ratio) >> 14;
    if (sat > 65536) sat = 65536;
    if (p.op == hcs_pkg::OP_SHADE) begin
      lit = (lit * p.ratio) >> 14;
      if (lit > 131072) lit = 131072;
    end
    if (sat == 0) begin
      ro = lit; go = lit; bo = lit;
    end else begin
      if (lit <= 65536) m2 = (lit * (65536 + sat)) >> 16;
      else m2 = (lit * (65536 - sat) + sat * 131072) >> 16;
      m1 = 2 * lit - m2;
      ro = ramp((hue + 2 * 65536) % full, m1, m2);
      go = ramp(hue, m1, m2);
      bo = ramp((hue + 4 * 65536) % full, m1, m2);
    end
    res.r = chan(ro); res.g = chan(go); res.b = chan(bo); res.a = p.a;
    return res;
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_chan();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'(32'h8000 + $urandom_range(0, 3) - 2);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic add_pixel(hcs_pkg::op_t op, logic [15:0] r, logic [15:0] g,
                           logic [15:0] b, logic [15:0] a, logic [15:0] ratio);
    pixel_t p;
    p.op = op; p.r = r; p.g = g; p.b = b; p.a = a; p.ratio = ratio;
    pending_pixels.push_back(p);
  endtask

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      pix_in.valid <= 1'b0;
    end else if (pix_in.valid && !pix_in.ready) begin
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      pix_in.valid <= 1'b0;
    end else if (hold_for_drain && shaded_pixels.size() != 0) begin
      pix_in.valid <= 1'b0;
    end else if (pending_pixels.size() != 0) begin
      pixel_t p;
      rgba_t e;
      p = pending_pixels.pop_front();
      e = shade_pixel(p);
      shaded_pixels.push_back(e);
      pix_in.valid <= 1'b1;
      pix_in.opcode <= p.op;
      pix_in.red_in <= p.r;
      pix_in.green_in <= p.g;
      pix_in.blue_in <= p.b;
      pix_in.alpha_in <= p.a;
      pix_in.ratio <= p.ratio;
      gap_left <= pick_gap();
    end else begin
      pix_in.valid <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && pix_out.valid && pix_out.ready) begin
      if (shaded_pixels.size() == 0) begin
        $display("%0t: unexpected transfer r=%h g=%h b=%h a=%h", $time, pix_out.red_out,
                 pix_out.green_out, pix_out.blue_out, pix_out.alpha_out);
        errors <= errors + 1;
      end else begin
        rgba_t e;
        e = shaded_pixels.pop_front();
        if (e.r !== pix_out.red_out || e.g !== pix_out.green_out ||
            e.b !== pix_out.blue_out || e.a !== pix_out.alpha_out) begin
          $display("%0t: expected r=%h g=%h b=%h a=%h, actual r=%h g=%h b=%h a=%h",
                   $time, e.r, e.g, e.b, e.a, pix_out.red_out, pix_out.green_out,
                   pix_out.blue_out, pix_out.alpha_out);
          errors <= errors + 1;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      pix_out.ready <= 1'b0;
    end else begin
      pix_out.ready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  initial begin
    pix_in.valid = 1'b0;
    pix_in.opcode = 1'b0;
    pix_in.red_in = '0;
    pix_in.green_in = '0;
    pix_in.blue_in = '0;
    pix_in.alpha_in = '0;
    pix_in.ratio = '0;
    pix_out.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    add_pixel(hcs_pkg::OP_SHADE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_pixel(hcs_pkg::OP_SHADE, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    add_pixel(hcs_pkg::OP_SATURATE, 16'h8000, 16'h8000, 16'h8000, 16'h1234, 16'h4000);
    add_pixel(hcs_pkg::OP_SHADE, 16'hffff, 16'h0000, 16'h0000, 16'hffff, 16'h4000);
    add_pixel(hcs_pkg::OP_SATURATE, 16'h0000, 16'hffff, 16'h0000, 16'h0001, 16'hffff);
    add_pixel(hcs_pkg::OP_SHADE, 16'h0000, 16'h0000, 16'hffff, 16'h8000, 16'h8000);
    add_pixel(hcs_pkg::OP_SATURATE, 16'hffff, 16'hffff, 16'h0000, 16'h5555, 16'h6000);
    add_pixel(hcs_pkg::OP_SHADE, 16'h0000, 16'hffff, 16'hffff, 16'haaaa, 16'h2000);
    add_pixel(hcs_pkg::OP_SATURATE, 16'hffff, 16'h0000, 16'hffff, 16'h0f0f, 16'h4000);
    add_pixel(hcs_pkg::OP_SHADE, 16'h4000, 16'h8000, 16'h8000, 16'h0000, 16'h4000);
    add_pixel(hcs_pkg::OP_SATURATE, 16'h8000, 16'h4000, 16'h8000, 16'h0000, 16'h0000);
    add_pixel(hcs_pkg::OP_SHADE, 16'hc000, 16'h2000, 16'h4000, 16'hffff, 16'h0001);
    add_pixel(hcs_pkg::OP_SATURATE, 16'h2000, 16'h4000, 16'hc000, 16'h7fff, 16'hc000);
    add_pixel(hcs_pkg::OP_SHADE, 16'h8001, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    add_pixel(hcs_pkg::OP_SATURATE, 16'h0001, 16'h0000, 16'h0000, 16'h0001, 16'h8000);
    add_pixel(hcs_pkg::OP_SHADE, 16'hfffe, 16'hffff, 16'hfffe, 16'hfffe, 16'h4001);
    add_pixel(hcs_pkg::OP_SHADE, 16'h8000, 16'h8000, 16'h8000, 16'h2222, 16'hffff);
    add_pixel(hcs_pkg::OP_SATURATE, 16'hf000, 16'hf000, 16'h1000, 16'h3333, 16'hffff);
    wait (pending_pixels.size() == 0);

    for (int i = 0; i < 1850; i++) begin
      if (i == 900) begin
        wait (pending_pixels.size() == 0);
        hold_for_drain = 1'b1;
        @(posedge clk);
        wait (shaded_pixels.size() == 0);
        hold_for_drain = 1'b0;
      end
      add_pixel(hcs_pkg::op_t'($urandom_range(0, 1)), pick_chan(), pick_chan(), pick_chan(),
                16'($urandom()), ($urandom_range(0, 3) == 0) ? 16'h4000 : 16'($urandom()));
      if (pending_pixels.size() > 16) wait (pending_pixels.size() <= 4);
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (!rst && stim_done && pending_pixels.size() == 0 && shaded_pixels.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule

// File: sim.f
design/hcs_pkg.sv
design/hcs_if.sv
design/hcs_front.sv
design/hcs_divider.sv
design/hcs_back.sv
design/hsl_color_shade_unit.sv
bench/testbench.sv
